@@ hdl/trle_pkg.sv @@
// ----------------------------------------------------------------------------
// trle_pkg
// Shared constants for the threshold run-length encoder: defaults, register
// indexes, register reset values, fixed field widths and result queue sizing.
// ----------------------------------------------------------------------------
package trle_pkg;

  // default sizing
  localparam int MaxPacketBitsDef = 18;
  localparam int VoxelWidthDef    = 8;
  localparam int TotalWidthDef    = 40;

  // fixed field widths
  localparam int RunLenW    = 17;
  localparam int ThreshW    = 8;
  localparam int PktBitsCfgW = 5;

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgThreshold  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPacketBits = 1'd1;

  // register reset values
  localparam logic [ThreshW-1:0]     ThresholdRst  = 8'd25;
  localparam logic [PktBitsCfgW-1:0] PacketBitsRst = 5'd3;

  // result queue sizing
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

endpackage

@@ hdl/threshold_run_length_encoder.sv @@
// ----------------------------------------------------------------------------
// threshold_run_length_encoder
// Thresholds voxels to one bit and run-length encodes the bit stream into
// capped-length packets with a running compressed-size total.
// ----------------------------------------------------------------------------
// Takes one voxel per clock while the result queue has room. A voxel is
// registered, then classified and encoded from that register, and its packets
// (zero, one or two) land in a four-entry result queue, from which the first
// packet is offered on the output port. The input side keeps taking one voxel
// per cycle as long as the queue has room for two packets; since the output
// port moves one packet per cycle while m_axis_tready is high, voxels that
// close two packets at once take longer to drain, and a stalled output fills
// the queue and then holds the input. Packets carry the run value, its length
// and the saturating bit total; tlast marks the packet that closes the volume,
// tuser the last packet caused by one voxel.
module threshold_run_length_encoder #(
  parameter int MAX_PACKET_BITS = trle_pkg::MaxPacketBitsDef,
  parameter int VOXEL_WIDTH     = trle_pkg::VoxelWidthDef,
  parameter int TOTAL_WIDTH     = trle_pkg::TotalWidthDef,
  localparam int InDataW  = ((VOXEL_WIDTH + 7) / 8) * 8,
  localparam int OutDataW = ((1 + trle_pkg::RunLenW + TOTAL_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [trle_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [trle_pkg::CfgDataW-1:0] cfg_wdata_i,
  // voxel stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [InDataW-1:0]            s_axis_tdata,   // voxel
  input  logic                          s_axis_tlast,   // final_voxel
  // packet stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OutDataW-1:0]           m_axis_tdata,   // run_bit, run_size, bit_sum
  output logic                          m_axis_tlast,   // end_of_volume
  output logic                          m_axis_tuser    // last_in_step
);
  import trle_pkg::*;

  localparam int PbW   = $clog2(MAX_PACKET_BITS + 1);
  localparam int CapW  = (RunLenW > MAX_PACKET_BITS - 1) ? RunLenW : MAX_PACKET_BITS - 1;
  localparam int ShW   = $clog2(CapW + 1);
  localparam int VoxCW = (VOXEL_WIDTH > ThreshW) ? VOXEL_WIDTH : ThreshW;
  localparam int SumW  = TOTAL_WIDTH + 2;

  typedef struct packed {
    logic                   run_bit;
    logic [RunLenW-1:0]     run_size;
    logic [TOTAL_WIDTH-1:0] bit_sum;
    logic                   end_of_volume;
    logic                   last_in_step;
  } packet_t;

  // configuration
  logic [ThreshW-1:0]     thr_q;
  logic [PktBitsCfgW-1:0] pkt_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ThresholdRst;
      pkt_bits_q <= PacketBitsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgThreshold:  thr_q      <= cfg_wdata_i[ThreshW-1:0];
        CfgPacketBits: pkt_bits_q <= cfg_wdata_i[PktBitsCfgW-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                   in_vld_q;
  logic [VOXEL_WIDTH-1:0] voxel_q;
  logic                   fin_q;
  logic [QueueCntW-1:0]   cnt_q;
  logic                   advance;

  assign advance       = in_vld_q && (cnt_q <= QueueCntW'(QueueDepth - 2));
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      voxel_q <= s_axis_tdata[VOXEL_WIDTH-1:0];
      fin_q   <= s_axis_tlast;
    end
  end

  // run state
  logic                   open_q, open_d;
  logic                   cur_bit_q, cur_bit_d;
  logic [RunLenW-1:0]     cur_len_q, cur_len_d;
  logic [TOTAL_WIDTH-1:0] total_q, total_d;

  // effective packet width, clamped to the legal range
  logic [PbW-1:0] pb;
  always_comb begin
    if (pkt_bits_q < PktBitsCfgW'(2)) begin
      pb = PbW'(2);
    end else if (int'(pkt_bits_q) > MAX_PACKET_BITS) begin
      pb = PbW'(MAX_PACKET_BITS);
    end else begin
      pb = PbW'(pkt_bits_q);
    end
  end

  logic [ShW-1:0]  cap_shift;
  logic [CapW-1:0] cap;
  assign cap_shift = ShW'(CapW + 1 - int'(pb));
  assign cap       = {CapW{1'b1}} >> cap_shift;

  // saturating totals for the first and second packet of this voxel
  logic [SumW-1:0]        sum1, sum2, lim_ext;
  logic [TOTAL_WIDTH-1:0] tot1, tot2;
  assign lim_ext = SumW'({TOTAL_WIDTH{1'b1}});
  assign sum1    = SumW'(total_q) + SumW'(pb);
  assign sum2    = sum1 + SumW'(pb);
  assign tot1    = (sum1 > lim_ext) ? {TOTAL_WIDTH{1'b1}} : sum1[TOTAL_WIDTH-1:0];
  assign tot2    = (sum2 > lim_ext) ? {TOTAL_WIDTH{1'b1}} : sum2[TOTAL_WIDTH-1:0];

  logic               act_bit, differ, cap_hit, close_new;
  logic [RunLenW-1:0] new_len;
  logic [1:0]         n_push;
  packet_t            pkt_a, pkt_b;

  always_comb begin
    act_bit = VoxCW'(voxel_q) > VoxCW'(thr_q);
    differ  = open_q && (cur_bit_q != act_bit);
    if (open_q && !differ) begin
      new_len = cur_len_q + RunLenW'(1);
    end else begin
      new_len = RunLenW'(1);
    end
    cap_hit   = CapW'(new_len) >= cap;
    // new run leaves in this beat: on the cap or on the final voxel
    close_new = cap_hit || fin_q;
    n_push    = {1'b0, differ} + {1'b0, close_new};

    if (differ) begin
      pkt_a.run_bit  = cur_bit_q;
      pkt_a.run_size = cur_len_q;
    end else begin
      pkt_a.run_bit  = act_bit;
      pkt_a.run_size = new_len;
    end
    pkt_a.bit_sum       = tot1;
    pkt_a.last_in_step  = !(differ && close_new);
    pkt_a.end_of_volume = fin_q && !(differ && close_new);

    pkt_b.run_bit       = act_bit;
    pkt_b.run_size      = new_len;
    pkt_b.bit_sum       = tot2;
    pkt_b.last_in_step  = 1'b1;
    pkt_b.end_of_volume = fin_q;

    cur_bit_d = act_bit;
    if (fin_q) begin
      open_d    = 1'b0;
      cur_len_d = '0;
      total_d   = '0;
    end else begin
      open_d    = !cap_hit;
      cur_len_d = cap_hit ? '0 : new_len;
      case (n_push)
        2'd1:    total_d = tot1;
        2'd2:    total_d = tot2;
        default: total_d = total_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      cur_bit_q <= 1'b0;
      cur_len_q <= '0;
      total_q   <= '0;
    end else if (advance) begin
      open_q    <= open_d;
      cur_bit_q <= cur_bit_d;
      cur_len_q <= cur_len_d;
      total_q   <= total_d;
    end
  end

  // result queue: up to two writes, one read per cycle
  packet_t              queue_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic                 pop;
  logic [1:0]           n_wr;

  assign n_wr = advance ? n_push : 2'd0;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QueuePtrW'(n_wr);
      rd_q  <= rd_q + QueuePtrW'(pop);
      cnt_q <= cnt_q + QueueCntW'(n_wr) - QueueCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      queue_q[wr_q] <= pkt_a;
    end
    if (n_wr == 2'd2) begin
      queue_q[wr_q + QueuePtrW'(1)] <= pkt_b;
    end
  end

  packet_t head;
  assign head          = queue_q[rd_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = OutDataW'({head.bit_sum, head.run_size, head.run_bit});
  assign m_axis_tlast  = head.end_of_volume;
  assign m_axis_tuser  = head.last_in_step;

endmodule
